### design/ihfe_pkg.sv
// Shared types, codes and helper functions for the IPv4 header forward engine.
// No dependencies; every other design file imports this package.
package ihfe_pkg;

  // Request codes carried on in_req_type.
  localparam logic REQ_ADD_ROUTE = 1'b0;
  localparam logic REQ_HEADER    = 1'b1;

  // Configuration register index (paddr bit 2 selects it).
  localparam logic REG_LOCAL_ADDRESS = 1'b0;

  // Header word positions and limits.
  localparam logic [3:0] WORD_LENGTH      = 4'd0;
  localparam logic [3:0] WORD_TTL         = 4'd2;
  localparam logic [3:0] WORD_DEST        = 4'd4;
  localparam logic [3:0] MIN_HEADER_WORDS = 4'd5;
  localparam logic [5:0] MAX_PREFIX_LEN   = 6'd32;

  typedef enum logic [2:0] {
    VERDICT_LOCAL    = 3'd0,
    VERDICT_FORWARD  = 3'd1,
    VERDICT_DROP_TTL = 3'd2,
    VERDICT_NO_ROUTE = 3'd3,
    VERDICT_ADDED    = 3'd4,
    VERDICT_FULL     = 3'd5
  } verdict_t;

  // Token that walks down the row of route cells, one cell per cycle.
  typedef struct packed {
    logic        add;       // route add when set, lookup otherwise
    logic [31:0] key;       // masked prefix (add) or destination (lookup)
    logic [5:0]  len;       // prefix length of an add
    logic [31:0] hop;       // next hop to store (add) or best hop so far (lookup)
    logic        hit;       // duplicate seen (add) or some route matched (lookup)
    logic [5:0]  best_len;  // length of the best match so far
    logic        free;      // a free cell has claimed this add
  } tok_t;

  // End-of-walk control broadcast to every cell.
  typedef struct packed {
    logic commit;   // make the claimed cell valid
    logic release_claim; // drop any claim
  } cell_ctl_t;

  // Packet summary handed from the header tracker on the final word.
  typedef struct packed {
    logic [31:0] dest;
    logic        local_hit;
    logic        ttl_zero;
    logic [7:0]  new_ttl;
    logic [20:0] sum;
  } pkt_t;

  function automatic logic [31:0] mask_of(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'h0;
    end else begin
      m = 32'hFFFF_FFFF << (MAX_PREFIX_LEN - len);
    end
    return m;
  endfunction

  // Two folds bring a 21-bit one's complement sum down to 16 bits.
  function automatic logic [15:0] fold_csum(input logic [20:0] s);
    logic [16:0] f1;
    logic [16:0] f2;
    f1 = {1'b0, s[15:0]} + {12'h0, s[20:16]};
    f2 = {1'b0, f1[15:0]} + {16'h0, f1[16]};
    return ~f2[15:0];
  endfunction

endpackage

### design/ihfe_cell.sv
// One route table cell of the forward engine: holds one entry and passes the token on.
// Depends on ihfe_pkg (tok_t, cell_ctl_t, mask_of).
module ihfe_cell
  import ihfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      tok_in_valid,
  input  tok_t      tok_in,
  input  cell_ctl_t ctl,
  output logic      tok_out_valid,
  output tok_t      tok_out
);

  logic        valid_r;
  logic        claim_r;
  logic [31:0] prefix_r;
  logic [5:0]  len_r;
  logic [31:0] hop_r;
  logic        tok_valid_r;
  tok_t        tok_r;
  tok_t        tok_nxt;
  logic        claim_now;
  logic        look_match;

  assign look_match = valid_r && ((tok_in.key & mask_of(len_r)) == prefix_r);
  assign claim_now  = tok_in_valid && tok_in.add && !valid_r && !tok_in.free;

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.add) begin
      if (valid_r && prefix_r == tok_in.key && len_r == tok_in.len) begin
        tok_nxt.hit = 1'b1;
      end
      if (!valid_r && !tok_in.free) begin
        tok_nxt.free = 1'b1;
      end
    end else if (look_match && (!tok_in.hit || len_r > tok_in.best_len)) begin
      // Strictly longer wins, so the lowest index keeps a tie.
      tok_nxt.hit      = 1'b1;
      tok_nxt.best_len = len_r;
      tok_nxt.hop      = hop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      claim_r     <= 1'b0;
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in_valid;
      if (claim_now) begin
        claim_r <= 1'b1;
      end else if (ctl.release_claim) begin
        claim_r <= 1'b0;
      end
      if (ctl.commit && claim_r) begin
        valid_r <= 1'b1;
      end
    end
  end

  // Entry payload is written on claim; it is only read once the entry is valid.
  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (claim_now) begin
      prefix_r <= tok_in.key;
      len_r    <= tok_in.len;
      hop_r    <= tok_in.hop;
    end
  end

  assign tok_out_valid = tok_valid_r;
  assign tok_out       = tok_r;

endmodule

### design/ihfe_hdr.sv
// Header tracker of the forward engine: counts header words, keeps TTL and destination,
// and accumulates the checksum. Depends on ihfe_pkg (pkt_t and header constants).
module ihfe_hdr
  import ihfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        hdr_we,
  input  logic [31:0] hdr_word,
  input  logic [31:0] local_address,
  output logic        hdr_last,
  output pkt_t        pkt
);

  logic [3:0]  wc_r;
  logic [3:0]  hw_r;
  logic [7:0]  ttl_r;
  logic [31:0] dest_r;
  logic [20:0] sum_r;

  logic [3:0]  hw_cur;
  logic [7:0]  ttl_cur;
  logic [31:0] dest_cur;
  logic [7:0]  ttl_dec;
  logic [16:0] addend;
  logic [20:0] sum_nxt;
  logic [3:0]  total;
  logic [4:0]  wc_inc;

  always_comb begin
    hw_cur   = (wc_r == WORD_LENGTH) ? hdr_word[27:24] : hw_r;
    ttl_cur  = (wc_r == WORD_TTL) ? hdr_word[31:24] : ttl_r;
    dest_cur = (wc_r == WORD_DEST) ? hdr_word : dest_r;
    ttl_dec  = hdr_word[31:24] - 8'd1;
    if (wc_r == WORD_TTL) begin
      // The checksum half is skipped and the decremented TTL stands in.
      addend = {1'b0, ttl_dec, hdr_word[23:16]};
    end else begin
      addend = {1'b0, hdr_word[31:16]} + {1'b0, hdr_word[15:0]};
    end
    if (wc_r < hw_cur) begin
      sum_nxt = sum_r + {4'h0, addend};
    end else begin
      sum_nxt = sum_r;
    end
    total    = (hw_cur < MIN_HEADER_WORDS) ? MIN_HEADER_WORDS : hw_cur;
    wc_inc   = {1'b0, wc_r} + 5'd1;
    hdr_last = (wc_inc >= {1'b0, total});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r   <= '0;
      hw_r   <= '0;
      ttl_r  <= '0;
      dest_r <= '0;
      sum_r  <= '0;
    end else if (hdr_we) begin
      if (hdr_last) begin
        wc_r   <= '0;
        hw_r   <= '0;
        ttl_r  <= '0;
        dest_r <= '0;
        sum_r  <= '0;
      end else begin
        wc_r   <= wc_inc[3:0];
        hw_r   <= hw_cur;
        ttl_r  <= ttl_cur;
        dest_r <= dest_cur;
        sum_r  <= sum_nxt;
      end
    end
  end

  always_comb begin
    pkt.dest      = dest_cur;
    pkt.local_hit = (dest_cur == local_address);
    pkt.ttl_zero  = (ttl_cur == 8'd0);
    pkt.new_ttl   = ttl_cur - 8'd1;
    pkt.sum       = sum_nxt;
  end

endmodule

### design/ipv4_header_forward_engine_unit.sv
// Top level of the IPv4 header forward engine: header tracker, row of route cells,
// configuration port and result register. Depends on ihfe_pkg, ihfe_hdr and ihfe_cell.
//
//  channel   handshake                    word contents
//  -------   ---------------------------  ---------------------------------------------
//  input     start & !busy                in_req_type, in_header_word, in_route_*
//  result    out_valid (one cycle)        out_verdict, out_next_hop, out_new_ttl,
//                                         out_new_checksum
//  config    psel & penable & pwrite      local_address at byte address 0
//
// A header word that does not end its header leaves busy low, so such words can arrive
// back to back. A route add or the final header word launches a token down the row of
// ROUTE_ENTRIES cells, one cell per cycle; when it leaves the last cell its result word
// is registered onto the result ports and busy falls at that same edge, so these words
// cannot overlap: the next one is taken only once the walk is done. The walk through
// the cell row sets how long each such word takes.
// Reset (synchronous, active low) empties the route table and clears the packet state.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module ipv4_header_forward_engine_unit
  import ihfe_pkg::*;
#(
  parameter int ROUTE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [31:0] in_header_word,
  input  logic [31:0] in_route_prefix,
  input  logic [5:0]  in_route_mask_len,
  input  logic [31:0] in_route_next_hop,
  // Result channel.
  output logic        out_valid,
  output logic [2:0]  out_verdict,
  output logic [31:0] out_next_hop,
  output logic [7:0]  out_new_ttl,
  output logic [15:0] out_new_checksum,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] local_address_r;
  logic        busy_r;
  pkt_t        pkt_r;

  logic        accept;
  logic        hdr_we;
  logic        hdr_last;
  pkt_t        pkt;
  logic        launch;
  tok_t        launch_tok;
  logic [5:0]  clamp_len;
  cell_ctl_t   ctl;

  logic        tok_v [ROUTE_ENTRIES+1];
  tok_t        tok_a [ROUTE_ENTRIES+1];
  logic        tail_v;
  tok_t        tail;

  logic        out_valid_r;
  verdict_t    verdict_r;
  verdict_t    verdict_nxt;
  logic [31:0] hop_r;
  logic [31:0] hop_nxt;
  logic [7:0]  ttl_r;
  logic [7:0]  ttl_nxt;
  logic [15:0] csum_r;
  logic [15:0] csum_nxt;

  // Configuration register. Only register 0 exists; the word is always ready.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LOCAL_ADDRESS) ? local_address_r : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_LOCAL_ADDRESS) begin
      local_address_r <= pwdata;
    end
  end

  // Input acceptance and the header tracker.
  assign accept = start && !busy_r;
  assign hdr_we = accept && (in_req_type == REQ_HEADER);
  assign busy   = busy_r;

  ihfe_hdr u_hdr (
    .clk           (clk),
    .rst_n         (rst_n),
    .hdr_we        (hdr_we),
    .hdr_word      (in_header_word),
    .local_address (local_address_r),
    .hdr_last      (hdr_last),
    .pkt           (pkt)
  );

  // A route add or the last header word starts a walk down the cell row.
  assign launch    = accept && (in_req_type == REQ_ADD_ROUTE || hdr_last);
  assign clamp_len = (in_route_mask_len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN
                                                          : in_route_mask_len;

  always_comb begin
    launch_tok.hit      = 1'b0;
    launch_tok.best_len = '0;
    launch_tok.free     = 1'b0;
    if (in_req_type == REQ_ADD_ROUTE) begin
      launch_tok.add = 1'b1;
      launch_tok.key = in_route_prefix & mask_of(clamp_len);
      launch_tok.len = clamp_len;
      launch_tok.hop = in_route_next_hop;
    end else begin
      launch_tok.add = 1'b0;
      launch_tok.key = pkt.dest;
      launch_tok.len = '0;
      launch_tok.hop = '0;
    end
  end

  assign tok_v[0] = launch;
  assign tok_a[0] = launch_tok;

  for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
    ihfe_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .tok_in_valid  (tok_v[i]),
      .tok_in        (tok_a[i]),
      .ctl           (ctl),
      .tok_out_valid (tok_v[i+1]),
      .tok_out       (tok_a[i+1])
    );
  end

  assign tail_v = tok_v[ROUTE_ENTRIES];
  assign tail   = tok_a[ROUTE_ENTRIES];

  // When the token leaves the last cell, an add without a duplicate turns the
  // claimed free cell valid; every claim is dropped either way.
  always_comb begin
    ctl.release_claim = tail_v;
    ctl.commit        = tail_v && tail.add && !tail.hit && tail.free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (launch) begin
      busy_r <= 1'b1;
    end else if (tail_v) begin
      busy_r <= 1'b0;
    end
  end

  // The packet summary waits here while its lookup walks the row.
  always_ff @(posedge clk) begin
    if (hdr_we && hdr_last) begin
      pkt_r <= pkt;
    end
  end

  // Verdict of an add: added or full. Of a lookup: local address, expired TTL, route.
  always_comb begin
    hop_nxt  = '0;
    ttl_nxt  = '0;
    csum_nxt = '0;
    if (tail.add) begin
      if (tail.hit || tail.free) begin
        verdict_nxt = VERDICT_ADDED;
      end else begin
        verdict_nxt = VERDICT_FULL;
      end
    end else if (pkt_r.local_hit) begin
      verdict_nxt = VERDICT_LOCAL;
    end else if (pkt_r.ttl_zero) begin
      verdict_nxt = VERDICT_DROP_TTL;
    end else if (!tail.hit) begin
      verdict_nxt = VERDICT_NO_ROUTE;
    end else begin
      verdict_nxt = VERDICT_FORWARD;
      hop_nxt     = tail.hop;
      ttl_nxt     = pkt_r.new_ttl;
      csum_nxt    = fold_csum(pkt_r.sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tail_v;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_v) begin
      verdict_r <= verdict_nxt;
      hop_r     <= hop_nxt;
      ttl_r     <= ttl_nxt;
      csum_r    <= csum_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = verdict_r;
  assign out_next_hop     = hop_r;
  assign out_new_ttl      = ttl_r;
  assign out_new_checksum = csum_r;

endmodule

### verif/ihfe_forward_checker.sv
`timescale 1ns / 1ps
// Checker for the IPv4 header forward engine: watches the input, result and configuration
// ports, keeps its own route table and header state, and compares every result word.
// Depends on ihfe_pkg for the request, register and verdict codes and the header limits.
module ihfe_forward_checker
  import ihfe_pkg::*;
#(
  parameter int ROUTE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        req_type,
  input  logic [31:0] header_word,
  input  logic [31:0] route_prefix,
  input  logic [5:0]  route_mask_len,
  input  logic [31:0] route_next_hop,
  input  logic        out_valid,
  input  logic [2:0]  verdict,
  input  logic [31:0] next_hop,
  input  logic [7:0]  new_ttl,
  input  logic [15:0] new_checksum,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] hop;
    logic [7:0]  ttl;
    logic [15:0] csum;
  } fwd_word_t;

  logic [31:0] node_addr;
  logic [31:0] tbl_prefix [ROUTE_ENTRIES];
  logic [5:0]  tbl_len    [ROUTE_ENTRIES];
  logic [31:0] tbl_hop    [ROUTE_ENTRIES];
  logic        tbl_valid  [ROUTE_ENTRIES];

  logic [20:0] hdr_sum;
  logic [3:0]  hdr_index;
  logic [3:0]  hdr_len;
  logic [7:0]  hdr_ttl;
  logic [31:0] hdr_dest;

  fwd_word_t   due_words [$];
  fwd_word_t   head;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    return ~(32'hFFFF_FFFF >> len);
  endfunction

  task automatic report_failure(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_header();
    hdr_sum   = '0;
    hdr_index = '0;
    hdr_len   = '0;
    hdr_ttl   = '0;
    hdr_dest  = '0;
  endtask

  // A duplicate is acknowledged without touching the stored hop; otherwise the
  // lowest free entry takes the route, and with none free the table is full.
  task automatic predict_route_add(input logic [31:0] pre_in, input logic [5:0] len_in,
                                   input logic [31:0] hop);
    logic [5:0]  len;
    logic [31:0] pre;
    int          slot;
    bit          dup;
    fwd_word_t   r;
    len  = (len_in > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : len_in;
    pre  = pre_in & prefix_mask(len);
    slot = -1;
    dup  = 1'b0;
    r    = '0;
    for (int i = 0; i < ROUTE_ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        if (tbl_prefix[i] == pre && tbl_len[i] == len) dup = 1'b1;
      end else if (slot < 0) begin
        slot = i;
      end
    end
    if (dup) begin
      r.verdict = VERDICT_ADDED;
    end else if (slot < 0) begin
      r.verdict = VERDICT_FULL;
    end else begin
      tbl_prefix[slot] = pre;
      tbl_len[slot]    = len;
      tbl_hop[slot]    = hop;
      tbl_valid[slot]  = 1'b1;
      r.verdict        = VERDICT_ADDED;
    end
    due_words.push_back(r);
  endtask

  task automatic predict_header_word(input logic [31:0] w);
    logic [3:0]  idx;
    logic [3:0]  total;
    logic [7:0]  dec_ttl;
    logic [31:0] folded;
    int          best;
    fwd_word_t   r;
    idx = hdr_index;
    if (idx == WORD_LENGTH) hdr_len = w[27:24];
    if (idx == WORD_TTL) hdr_ttl = w[31:24];
    if (idx == WORD_DEST) hdr_dest = w;
    // The checksum half is skipped and the TTL byte is summed already decremented.
    if (idx < hdr_len) begin
      if (idx == WORD_TTL) begin
        dec_ttl = w[31:24] - 8'd1;
        hdr_sum = hdr_sum + {dec_ttl, w[23:16]};
      end else begin
        hdr_sum = hdr_sum + w[31:16] + w[15:0];
      end
    end
    total = (hdr_len < MIN_HEADER_WORDS) ? MIN_HEADER_WORDS : hdr_len;
    if (idx + 1 < total) begin
      hdr_index = idx + 4'd1;
      return;
    end
    r    = '0;
    best = -1;
    if (hdr_dest == node_addr) begin
      r.verdict = VERDICT_LOCAL;
    end else if (hdr_ttl == 8'd0) begin
      r.verdict = VERDICT_DROP_TTL;
    end else begin
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
        if (tbl_valid[i] && (hdr_dest & prefix_mask(tbl_len[i])) == tbl_prefix[i] &&
            (best < 0 || tbl_len[i] > tbl_len[best])) best = i;
      end
      if (best < 0) begin
        r.verdict = VERDICT_NO_ROUTE;
      end else begin
        folded = hdr_sum;
        while (folded[31:16] != 16'd0) folded = folded[15:0] + folded[31:16];
        r.verdict = VERDICT_FORWARD;
        r.hop     = tbl_hop[best];
        r.ttl     = hdr_ttl - 8'd1;
        r.csum    = ~folded[15:0];
      end
    end
    due_words.push_back(r);
    clear_header();
  endtask

  // Results are compared before the same edge's input is predicted, since a result
  // always belongs to a word accepted at an earlier edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      node_addr = '0;
      for (int i = 0; i < ROUTE_ENTRIES; i++) tbl_valid[i] = 1'b0;
      clear_header();
      due_words.delete();
    end else begin
      if (out_valid) begin
        if (due_words.size() == 0) begin
          report_failure($sformatf("result word with none expected, verdict %0d", verdict));
        end else begin
          head = due_words.pop_front();
          if (verdict !== head.verdict)
            report_failure($sformatf("verdict: got %0d, expected %0d", verdict, head.verdict));
          if (next_hop !== head.hop)
            report_failure($sformatf("next_hop: got %h, expected %h", next_hop, head.hop));
          if (new_ttl !== head.ttl)
            report_failure($sformatf("new_ttl: got %h, expected %h", new_ttl, head.ttl));
          if (new_checksum !== head.csum)
            report_failure($sformatf("new_checksum: got %h, expected %h",
                                     new_checksum, head.csum));
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_LOCAL_ADDRESS)
        node_addr = pwdata;
      if (start && !busy) begin
        if (req_type == REQ_ADD_ROUTE) begin
          predict_route_add(route_prefix, route_mask_len, route_next_hop);
        end else begin
          predict_header_word(header_word);
        end
      end
    end
    pending = due_words.size();
  end

endmodule

### verif/tb_ipv4_header_forward_engine_unit.sv
`timescale 1ns / 1ps
// Top of the forward engine testbench: clock, reset, stimulus and the final verdict.
// Depends on ihfe_pkg, ipv4_header_forward_engine_unit and ihfe_forward_checker.
module tb_ipv4_header_forward_engine_unit;
  import ihfe_pkg::*;

  localparam int ROUTE_ENTRIES = 64;
  // A route add or a final header word walks the whole cell row before its result
  // shows, so this many quiet cycles cover any work still in flight.
  localparam int SETTLE_CYCLES = ROUTE_ENTRIES + 4;

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        start             = 1'b0;
  logic        busy;
  logic        in_req_type       = REQ_ADD_ROUTE;
  logic [31:0] in_header_word    = '0;
  logic [31:0] in_route_prefix   = '0;
  logic [5:0]  in_route_mask_len = '0;
  logic [31:0] in_route_next_hop = '0;
  logic        out_valid;
  logic [2:0]  out_verdict;
  logic [31:0] out_next_hop;
  logic [7:0]  out_new_ttl;
  logic [15:0] out_new_checksum;
  logic        psel              = 1'b0;
  logic        penable           = 1'b0;
  logic        pwrite            = 1'b0;
  logic [2:0]  paddr             = '0;
  logic [31:0] pwdata            = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;

  // Stimulus knobs: percent of idle cycles before each word, percent of route adds
  // among random transactions, and whether default routes may be added yet.
  int          gap_pct       = 26;
  int          add_pct       = 35;
  bit          allow_default = 1'b0;
  int          items_sent    = 0;
  logic [31:0] node_addr     = '0;
  // Masked prefixes and lengths sent so far, so destinations can be aimed at routes.
  logic [31:0] route_keys [$];
  logic [5:0]  route_lens [$];

  always #5 clk = ~clk;

  ipv4_header_forward_engine_unit #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_header_word   (in_header_word),
    .in_route_prefix  (in_route_prefix),
    .in_route_mask_len(in_route_mask_len),
    .in_route_next_hop(in_route_next_hop),
    .out_valid        (out_valid),
    .out_verdict      (out_verdict),
    .out_next_hop     (out_next_hop),
    .out_new_ttl      (out_new_ttl),
    .out_new_checksum (out_new_checksum),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  ihfe_forward_checker #(
    .ROUTE_ENTRIES(ROUTE_ENTRIES)
  ) u_forward_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .req_type      (in_req_type),
    .header_word   (in_header_word),
    .route_prefix  (in_route_prefix),
    .route_mask_len(in_route_mask_len),
    .route_next_hop(in_route_next_hop),
    .out_valid     (out_valid),
    .verdict       (out_verdict),
    .next_hop      (out_next_hop),
    .new_ttl       (out_new_ttl),
    .new_checksum  (out_new_checksum),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Every task is entered and left just after a rising edge. The word is offered
  // from that edge on; busy only changes at rising edges, so looking at it at the
  // falling edge tells whether the next rising edge accepts the word. start stays
  // high from one word to the next when there is no gap, so it is never lowered
  // and raised again in the same step.
  task automatic send_word(input logic kind, input logic [31:0] hw, input logic [31:0] pre,
                           input logic [5:0] len, input logic [31:0] hop);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start             <= 1'b1;
    in_req_type       <= kind;
    in_header_word    <= hw;
    in_route_prefix   <= pre;
    in_route_mask_len <= len;
    in_route_next_hop <= hop;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
    items_sent++;
  endtask

  // Records the route as the table would key it, then offers it. The header word
  // field carries noise, which the block must ignore on a route add.
  task automatic add_route(input logic [31:0] pre, input logic [5:0] len,
                           input logic [31:0] hop);
    logic [5:0] eff;
    eff = (len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : len;
    route_keys.push_back(pre & ~(32'hFFFF_FFFF >> eff));
    route_lens.push_back(eff);
    send_word(REQ_ADD_ROUTE, $urandom, pre, len, hop);
  endtask

  // Lengths cover the default route (once allowed), host routes, lengths past 32
  // that the block clamps, and everything in between. Some adds repeat a route
  // already sent, with different bits below the mask, to hit the duplicate case.
  task automatic add_random_route();
    int          r;
    int          k;
    logic [5:0]  len;
    logic [31:0] pre;
    r = $urandom_range(99);
    if (r < 10 && allow_default) begin
      len = 6'd0;
    end else if (r < 20) begin
      len = 6'd32;
    end else if (r < 30) begin
      len = 6'($urandom_range(33, 63));
    end else begin
      len = 6'($urandom_range(1, 31));
    end
    pre = $urandom;
    if (route_keys.size() > 0 && $urandom_range(99) < 15) begin
      k   = $urandom_range(route_keys.size() - 1);
      len = route_lens[k];
      pre = route_keys[k] | ($urandom & (32'hFFFF_FFFF >> len));
    end
    add_route(pre, len, $urandom);
  endtask

  // Sends one header of max(hl, 5) words. A well-formed header has version 4 in
  // its first nibble; a broken one has random bits there and is more often split
  // by route adds, which must leave the header in progress untouched.
  task automatic send_packet(input logic [3:0] hl, input logic [7:0] ttl,
                             input logic [31:0] dest, input bit noise);
    logic [31:0] w;
    int          total;
    total = (hl < MIN_HEADER_WORDS) ? MIN_HEADER_WORDS : hl;
    for (int i = 0; i < total; i++) begin
      w = $urandom;
      if (i == WORD_LENGTH) begin
        w[27:24] = hl;
        if (!noise) w[31:28] = 4'h4;
      end
      if (i == WORD_TTL) w[31:24] = ttl;
      if (i == WORD_DEST) w = dest;
      if ($urandom_range(99) < (noise ? 20 : 3)) add_random_route();
      send_word(REQ_HEADER, w, $urandom, 6'($urandom), $urandom);
    end
  endtask

  // TTL leans toward zero, one and the maximum; the destination is aimed at a
  // known route, at this node's address, or left to chance.
  task automatic random_packet();
    int          r;
    int          k;
    bit          noise;
    logic [3:0]  hl;
    logic [7:0]  ttl;
    logic [31:0] dest;
    logic [5:0]  len;
    noise = ($urandom_range(99) < 25);
    if (noise) begin
      hl = 4'($urandom_range(0, 15));
    end else begin
      hl = ($urandom_range(99) < 60) ? MIN_HEADER_WORDS : 4'($urandom_range(5, 15));
    end
    r = $urandom_range(99);
    if (r < 10) begin
      ttl = 8'd0;
    end else if (r < 15) begin
      ttl = 8'd1;
    end else if (r < 20) begin
      ttl = 8'hFF;
    end else begin
      ttl = 8'($urandom_range(2, 254));
    end
    r = $urandom_range(99);
    if (r < 45 && route_keys.size() > 0) begin
      k    = $urandom_range(route_keys.size() - 1);
      len  = route_lens[k];
      dest = route_keys[k] | ($urandom & (32'hFFFF_FFFF >> len));
    end else if (r < 60) begin
      dest = node_addr;
    end else begin
      dest = $urandom;
    end
    send_packet(hl, ttl, dest, noise);
  endtask

  task automatic random_phase(input int until_items);
    while (items_sent < until_items) begin
      if ($urandom_range(99) < add_pct) begin
        add_random_route();
      end else begin
        random_packet();
      end
    end
  endtask

  // Waits until every expected result word has come, then lets the cell row drain.
  task automatic settle();
    start <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge that
  // ends the access cycle. The task returns only after an edge with psel low, so
  // back-to-back writes never lower and raise psel in the same step.
  task automatic write_local(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_LOCAL_ADDRESS, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    forever begin
      @(negedge clk);
      if (pready) break;
    end
    @(posedge clk);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    node_addr = value;
    @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with this node at the all-ones address. The routes give a
    // host route inside a shorter prefix, a length past 32 and a duplicate prefix
    // whose next hop must not replace the stored one.
    write_local(32'hFFFF_FFFF);
    add_route(32'h0A01_0203, 6'd32, 32'h1111_1111);
    add_route(32'h0A00_0000, 6'd8, 32'h2222_2222);
    add_route(32'hC0A8_0007, 6'd45, 32'h3333_3333);
    add_route(32'h0A09_0909, 6'd8, 32'h4444_4444);
    // Longest match with the largest TTL.
    send_packet(4'd5, 8'hFF, 32'h0A01_0203, 1'b0);
    // Header length zero still takes five words; the destination is this node.
    send_packet(4'd0, 8'd64, 32'hFFFF_FFFF, 1'b0);
    // TTL zero on a routable destination, with a short header length.
    send_packet(4'd2, 8'd0, 32'h0A05_0505, 1'b0);
    // TTL one with no matching route and no default route yet.
    send_packet(4'd5, 8'd1, 32'h0B00_0000, 1'b0);
    settle();

    // Random node address, ordinary idling, no default route.
    write_local($urandom);
    random_phase(170);
    settle();

    // Node at address zero, default routes allowed, and no idle cycles at all.
    write_local(32'h0);
    allow_default = 1'b1;
    gap_pct       = 0;
    random_phase(300);
    settle();

    // Mostly route adds, so the table fills and later adds are turned away.
    write_local($urandom);
    gap_pct = 26;
    add_pct = 70;
    random_phase(460);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every word a full walk of the cell row
  // plus the longest idle stretch.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
design/ihfe_pkg.sv
design/ihfe_cell.sv
design/ihfe_hdr.sv
design/ipv4_header_forward_engine_unit.sv
verif/ihfe_forward_checker.sv
verif/tb_ipv4_header_forward_engine_unit.sv
